@@ sv/hkt_pkg.sv @@
package hkt_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NEWLINE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_REPEAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_REPEAT  = 2'd2;

  localparam int unsigned IN_SLOTS = 6;

  localparam logic [7:0] KEY_CAPS_LOCK = 8'h39;
  localparam logic [7:0] KEY_NUM_LOCK  = 8'h53;
  localparam logic [7:0] CTRL_LO       = 8'h40;
  localparam logic [7:0] CTRL_HI       = 8'h5F;
  localparam logic [7:0] FIRST_RESET   = 8'd60;
  localparam logic [7:0] NEXT_RESET    = 8'd6;

  localparam logic [7:0] PLAIN_TAB [27] = '{
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h00, 8'h00, 8'h08, 8'h00, 8'h20,
    8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C, 8'h60, 8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E, 8'h2F
  };
  localparam logic [7:0] SHIFT_TAB [27] = '{
    8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
    8'h00, 8'h00, 8'h08, 8'h00, 8'h20,
    8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h7C, 8'h7E, 8'h3A, 8'h22, 8'h7E, 8'h3C, 8'h3E, 8'h3F
  };
  localparam logic [7:0] ARROW_TAB [4] = '{8'h43, 8'h44, 8'h42, 8'h41};

  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] b;
  } xlat_t;

  typedef struct packed {
    logic            new_caps;
    logic            new_num;
    logic            xlat;
    logic [7:0]      key;
    logic [1:0]      len;
    logic [2:0][7:0] b;
  } hkt_lane_t;

  function automatic xlat_t key_lookup(logic [7:0] key, logic up, logic nl);
    xlat_t      r;
    logic [7:0] c;
    logic [7:0] n;
    r = '0;
    c = '0;
    n = '0;
    if (key >= 8'h04 && key <= 8'h1D) begin
      r.len  = 2'd1;
      r.b[0] = (up ? 8'h41 : 8'h61) + (key - 8'h04);
    end else if (key == 8'h28) begin
      r.b[0] = 8'h0D;
      if (nl) begin
        r.b[1] = 8'h0A;
        r.len  = 2'd2;
      end else begin
        r.len = 2'd1;
      end
    end else if (key >= 8'h1E && key <= 8'h38) begin
      n = key - 8'h1E;
      c = up ? SHIFT_TAB[n[4:0]] : PLAIN_TAB[n[4:0]];
      if (c != 8'h00) begin
        r.len  = 2'd1;
        r.b[0] = c;
      end
    end else if (key >= 8'h3A && key <= 8'h45) begin
      n      = key - 8'h3A;
      r.len  = 2'd3;
      r.b[0] = 8'h1B;
      r.b[1] = 8'h5B;
      if (up) begin
        r.b[2] = (n < 8'd2) ? 8'h59 + n : 8'h61 + (n - 8'd2);
      end else begin
        r.b[2] = 8'h4D + n;
      end
    end else if (key >= 8'h4F && key <= 8'h52) begin
      n      = key - 8'h4F;
      r.len  = 2'd3;
      r.b[0] = 8'h1B;
      r.b[1] = 8'h5B;
      r.b[2] = ARROW_TAB[n[1:0]];
    end else if (key == 8'h4C) begin
      r.len  = 2'd1;
      r.b[0] = 8'h7F;
    end else if (key == 8'h63) begin
      r.len  = 2'd1;
      r.b[0] = up ? 8'h2E : 8'h7F;
    end
    return r;
  endfunction

endpackage

@@ sv/hkt_lane.sv @@
module hkt_lane #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic [7:0]        key_i,
  input  logic [7:0]        prev_keys_i [KEY_SLOTS],
  input  logic              shift_i,
  input  logic              ctrl_i,
  input  logic              caps_i,
  input  logic              newline_mode_i,
  output hkt_pkg::hkt_lane_t lane_o
);
  import hkt_pkg::*;

  logic  seen;
  logic  letter;
  logic  up;
  xlat_t sb;
  xlat_t tb;

  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (prev_keys_i[j] == key_i) seen = 1'b1;
    end
  end

  always_comb begin
    sb     = key_lookup(key_i, 1'b1, newline_mode_i);
    letter = (key_i >= 8'h04) && (key_i <= 8'h1D);
    up     = (caps_i && letter) != shift_i;
    if (ctrl_i && sb.len == 2'd1 && sb.b[0] >= CTRL_LO && sb.b[0] <= CTRL_HI) begin
      tb      = '0;
      tb.len  = 2'd1;
      tb.b[0] = sb.b[0] - CTRL_LO;
    end else begin
      tb = key_lookup(key_i, up, newline_mode_i);
    end
  end

  always_comb begin
    lane_o.new_caps = !seen && (key_i == KEY_CAPS_LOCK);
    lane_o.new_num  = !seen && (key_i == KEY_NUM_LOCK);
    lane_o.xlat     = !seen && (key_i != KEY_CAPS_LOCK) && (key_i != KEY_NUM_LOCK)
                      && (sb.len != 2'd0);
    lane_o.key      = key_i;
    lane_o.len      = tb.len;
    lane_o.b        = tb.b;
  end

endmodule

@@ sv/hid_key_report_to_ascii_typematic.sv @@
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o | op, modifier_bits, key_slot_0..5
// out     | output    | out_valid_o/out_ready_i | out_char, char_valid, last, LEDs, changed
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
// A report is translated by one lane per key slot into the registered result buffer; its
// bytes then leave one per cycle while out_ready_i is high, so an item makes max(1, bytes)
// transfers (1 to 18). A tick that sends nothing makes no transfer. The next item is taken
// in the cycle the last result of the current one transfers. Reset is asynchronous, active low.
module hid_key_report_to_ascii_typematic #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hkt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      op_i,
  input  logic [7:0]                modifier_bits_i,
  input  logic [7:0]                key_slot_0_i,
  input  logic [7:0]                key_slot_1_i,
  input  logic [7:0]                key_slot_2_i,
  input  logic [7:0]                key_slot_3_i,
  input  logic [7:0]                key_slot_4_i,
  input  logic [7:0]                key_slot_5_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_char_o,
  output logic                      char_valid_o,
  output logic                      last_o,
  output logic                      caps_lock_led_o,
  output logic                      num_lock_led_o,
  output logic                      led_report_changed_o
);
  import hkt_pkg::*;

  localparam int unsigned LW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic            nl_q;
  logic [7:0]      first_q, next_q;
  logic [7:0]      prev_q [KEY_SLOTS];
  logic            pshift_q, pctrl_q, caps_q, num_q;
  logic [7:0]      held_q, held_d;
  logic [2:0][7:0] hstr_q, hstr_d;
  logic [1:0]      hlen_q, hlen_d;
  logic [7:0]      cnt_q, cnt_d, lim_q, lim_d;
  logic            caps_d, num_d;

  logic            job_v_q, job_v_d;
  logic [KEY_SLOTS-1:0] pend_q, pend_d;
  logic [1:0]      bidx_q, bidx_d;
  logic [2:0][7:0] jb_q [KEY_SLOTS];
  logic [2:0][7:0] jb_d [KEY_SLOTS];
  logic [1:0]      jl_q [KEY_SLOTS];
  logic [1:0]      jl_d [KEY_SLOTS];
  logic            jcaps_q, jnum_q, jchg_q, jcaps_d, jnum_d, jchg_d;

  logic [7:0]      slots [KEY_SLOTS];
  logic            lane_caps [KEY_SLOTS];
  hkt_lane_t       lanes [KEY_SLOTS];
  logic            shift, ctrl, present, changed, capsv, numv, fire;
  logic [7:0]      cnt_inc;
  logic            in_xfer, out_xfer;
  logic [LW-1:0]   cur;
  logic            lane_end;

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) slots[i] = 8'h00;
    slots[0] = key_slot_0_i;
    if (KEY_SLOTS > 1) slots[1 % KEY_SLOTS] = key_slot_1_i;
    if (KEY_SLOTS > 2) slots[2 % KEY_SLOTS] = key_slot_2_i;
    if (KEY_SLOTS > 3) slots[3 % KEY_SLOTS] = key_slot_3_i;
    if (KEY_SLOTS > 4) slots[4 % KEY_SLOTS] = key_slot_4_i;
    if (KEY_SLOTS > 5) slots[5 % KEY_SLOTS] = key_slot_5_i;
  end

  assign shift = modifier_bits_i[1] | modifier_bits_i[5];
  assign ctrl  = modifier_bits_i[0] | modifier_bits_i[4];

  always_comb begin
    capsv = caps_q;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      lane_caps[i] = capsv;
      if (lanes[i].new_caps) capsv = ~capsv;
    end
  end

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    hkt_lane #(.KEY_SLOTS(KEY_SLOTS)) u_lane (
      .key_i          (slots[g]),
      .prev_keys_i    (prev_q),
      .shift_i        (shift),
      .ctrl_i         (ctrl),
      .caps_i         (lane_caps[g]),
      .newline_mode_i (nl_q),
      .lane_o         (lanes[g])
    );
  end

  // merge: current buffer lane and end-of-item detection
  always_comb begin
    cur = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (pend_q[i]) cur = LW'(i);
    end
  end

  assign lane_end     = (bidx_q == jl_q[cur] - 2'd1);
  assign out_valid_o  = job_v_q;
  assign char_valid_o = |pend_q;
  assign out_char_o   = (|pend_q) ? jb_q[cur][bidx_q] : 8'h00;
  assign last_o       = (pend_q == '0)
                        || (((pend_q & (pend_q - 1'b1)) == '0) && lane_end);
  assign caps_lock_led_o      = jcaps_q;
  assign num_lock_led_o       = jnum_q;
  assign led_report_changed_o = jchg_q;

  assign out_xfer   = out_valid_o && out_ready_i;
  assign in_ready_o = !job_v_q || (out_ready_i && last_o);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cnt_inc    = cnt_q + 8'd1;

  always_comb begin
    held_d  = held_q;
    hstr_d  = hstr_q;
    hlen_d  = hlen_q;
    cnt_d   = cnt_q;
    lim_d   = lim_q;
    caps_d  = caps_q;
    num_d   = num_q;
    changed = 1'b0;
    present = 1'b0;
    numv    = num_q;
    fire    = 1'b0;
    job_v_d = job_v_q;
    pend_d  = pend_q;
    bidx_d  = bidx_q;
    jb_d    = jb_q;
    jl_d    = jl_q;
    jcaps_d = jcaps_q;
    jnum_d  = jnum_q;
    jchg_d  = jchg_q;

    if (out_xfer) begin
      if (last_o) begin
        job_v_d = 1'b0;
      end else if (lane_end) begin
        pend_d[cur] = 1'b0;
        bidx_d      = 2'd0;
      end else begin
        bidx_d = bidx_q + 2'd1;
      end
    end

    if (in_xfer) begin
      if (op_i) begin
        if (held_q != 8'h00) begin
          if (cnt_inc >= lim_q) begin
            fire  = 1'b1;
            cnt_d = 8'h00;
            lim_d = next_q;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        if (fire) begin
          job_v_d = 1'b1;
          pend_d  = '0;
          pend_d[0] = (hlen_q != 2'd0);
          bidx_d  = 2'd0;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            jb_d[i] = '0;
            jl_d[i] = 2'd0;
          end
          jb_d[0] = hstr_q;
          jl_d[0] = hlen_q;
          jcaps_d = caps_q;
          jnum_d  = num_q;
          jchg_d  = 1'b0;
        end
      end else begin
        if ((ctrl && !pctrl_q) || (shift && !pshift_q)) held_d = 8'h00;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (slots[i] == held_d) present = 1'b1;
        end
        if (!present) held_d = 8'h00;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (lanes[i].new_caps || lanes[i].new_num) begin
            held_d  = 8'h00;
            changed = 1'b1;
            if (lanes[i].new_num) numv = ~numv;
          end else if (lanes[i].xlat) begin
            held_d = lanes[i].key;
            hstr_d = lanes[i].b;
            hlen_d = lanes[i].len;
            cnt_d  = 8'h00;
            lim_d  = first_q;
          end
          jb_d[i]   = lanes[i].b;
          jl_d[i]   = lanes[i].xlat ? lanes[i].len : 2'd0;
          pend_d[i] = lanes[i].xlat;
        end
        caps_d  = capsv;
        num_d   = numv;
        job_v_d = 1'b1;
        bidx_d  = 2'd0;
        jcaps_d = capsv;
        jnum_d  = numv;
        jchg_d  = changed;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_q     <= 1'b1;
      first_q  <= FIRST_RESET;
      next_q   <= NEXT_RESET;
      for (int i = 0; i < KEY_SLOTS; i++) prev_q[i] <= 8'h00;
      pshift_q <= 1'b0;
      pctrl_q  <= 1'b0;
      caps_q   <= 1'b0;
      num_q    <= 1'b0;
      held_q   <= 8'h00;
      hstr_q   <= '0;
      hlen_q   <= 2'd0;
      cnt_q    <= 8'h00;
      lim_q    <= FIRST_RESET;
      job_v_q  <= 1'b0;
      pend_q   <= '0;
      bidx_q   <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_NEWLINE_MODE: nl_q    <= cfg_data_i[0];
          REG_FIRST_REPEAT: first_q <= cfg_data_i;
          REG_NEXT_REPEAT:  next_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_xfer && !op_i) begin
        prev_q   <= slots;
        pshift_q <= shift;
        pctrl_q  <= ctrl;
      end
      held_q  <= held_d;
      hstr_q  <= hstr_d;
      hlen_q  <= hlen_d;
      cnt_q   <= cnt_d;
      lim_q   <= lim_d;
      caps_q  <= caps_d;
      num_q   <= num_d;
      job_v_q <= job_v_d;
      pend_q  <= pend_d;
      bidx_q  <= bidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    jb_q    <= jb_d;
    jl_q    <= jl_d;
    jcaps_q <= jcaps_d;
    jnum_q  <= jnum_d;
    jchg_q  <= jchg_d;
  end

endmodule

@@ dv/hid_key_report_to_ascii_typematic_test.sv @@
module hid_key_report_to_ascii_typematic_test;
  import hkt_pkg::*;

  localparam int LIMIT = 400000;
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       lst;
    logic       caps;
    logic       num;
    logic       chg;
  } kbd_out_t;

  typedef struct {
    logic       op;
    logic [7:0] mods;
    logic [7:0] k [6];
    logic       has_exp;
    logic [7:0] exp_ch;
    logic       exp_cv;
  } kbd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_NEWLINE_MODE;
  logic [7:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = 1'b0;
  logic [7:0] modifier_bits_i = '0;
  logic [7:0] key_slot_0_i = '0, key_slot_1_i = '0, key_slot_2_i = '0;
  logic [7:0] key_slot_3_i = '0, key_slot_4_i = '0, key_slot_5_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] out_char_o;
  logic char_valid_o, last_o, caps_lock_led_o, num_lock_led_o, led_report_changed_o;

  hid_key_report_to_ascii_typematic uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of block state
  logic       nl_mode;
  logic [7:0] first_ticks, next_ticks;
  logic [7:0] prev_keys [6];
  logic       prev_shift, prev_ctrl, caps_st, num_st;
  logic [7:0] held_key;
  logic [7:0] held_bytes [3];
  int         held_len;
  logic [7:0] rep_count, rep_limit;

  kbd_out_t   pending_bytes [$];
  int         errors = 0;
  int         cycles = 0;
  int         sent_items = 0, got_bytes = 0;
  int         send_idle = 24, recv_idle = 55;
  bit         hold_off = 1'b0;
  bit         row_check = 1'b0;
  logic [7:0] row_ch;
  logic       row_cv;

  function automatic int translate(logic [7:0] key, logic up, output logic [7:0] b [3]);
    logic [7:0] c;
    int n;
    b = '{default: 8'h00};
    if (key >= 8'h04 && key <= 8'h1D) begin
      b[0] = (up ? 8'h41 : 8'h61) + (key - 8'h04);
      return 1;
    end
    if (key == 8'h28) begin
      b[0] = 8'h0D;
      if (nl_mode) begin
        b[1] = 8'h0A;
        return 2;
      end
      return 1;
    end
    if (key >= 8'h1E && key <= 8'h38) begin
      n = key - 8'h1E;
      c = up ? SHIFT_TAB[n] : PLAIN_TAB[n];
      if (c == 8'h00) return 0;
      b[0] = c;
      return 1;
    end
    if (key >= 8'h3A && key <= 8'h45) begin
      n = key - 8'h3A;
      b[0] = 8'h1B;
      b[1] = 8'h5B;
      if (up) b[2] = (n < 2) ? 8'(8'h59 + n) : 8'(8'h61 + (n - 2));
      else b[2] = 8'(8'h4D + n);
      return 3;
    end
    if (key >= 8'h4F && key <= 8'h52) begin
      b[0] = 8'h1B;
      b[1] = 8'h5B;
      b[2] = ARROW_TAB[key - 8'h4F];
      return 3;
    end
    if (key == 8'h4C) begin
      b[0] = 8'h7F;
      return 1;
    end
    if (key == 8'h63) begin
      b[0] = up ? 8'h2E : 8'h7F;
      return 1;
    end
    return 0;
  endfunction

  task automatic queue_bytes(logic [7:0] bs [$], logic chg, bit status);
    kbd_out_t r;
    int cnt;
    cnt = bs.size();
    if (cnt == 0 && status) cnt = 1;
    for (int i = 0; i < cnt; i++) begin
      r.ch = bs.size() == 0 ? 8'h00 : bs[i];
      r.cv = bs.size() != 0;
      r.lst = i == cnt - 1;
      r.caps = caps_st;
      r.num = num_st;
      r.chg = chg;
      pending_bytes.push_back(r);
    end
  endtask

  task automatic predict_keyboard(logic op, logic [7:0] m, logic [7:0] k [6]);
    logic [7:0] bs [$];
    logic [7:0] sb [3], tb [3];
    logic shift, ctrl, chg, seen, present, letter, up;
    int len;
    chg = 1'b0;
    if (op == OP_TICK) begin
      if (held_key == 0) return;
      rep_count++;
      if (rep_count >= rep_limit) begin
        rep_count = 0;
        rep_limit = next_ticks;
        for (int i = 0; i < held_len; i++) bs.push_back(held_bytes[i]);
        queue_bytes(bs, 1'b0, 1'b0);
      end
      return;
    end
    shift = m[1] | m[5];
    ctrl = m[0] | m[4];
    if ((ctrl && !prev_ctrl) || (shift && !prev_shift)) held_key = 0;
    if (held_key != 0) begin
      present = 1'b0;
      foreach (k[i]) if (k[i] == held_key) present = 1'b1;
      if (!present) held_key = 0;
    end
    foreach (k[i]) begin
      seen = 1'b0;
      foreach (prev_keys[j]) if (prev_keys[j] == k[i]) seen = 1'b1;
      if (seen) continue;
      if (k[i] == KEY_CAPS_LOCK) begin
        caps_st = !caps_st;
        chg = 1'b1;
        held_key = 0;
        continue;
      end
      if (k[i] == KEY_NUM_LOCK) begin
        num_st = !num_st;
        chg = 1'b1;
        held_key = 0;
        continue;
      end
      len = translate(k[i], 1'b1, sb);
      if (len == 0) continue;
      if (ctrl && len == 1 && sb[0] >= CTRL_LO && sb[0] <= CTRL_HI) begin
        tb = '{default: 8'h00};
        tb[0] = sb[0] - CTRL_LO;
        len = 1;
      end else begin
        letter = k[i] >= 8'h04 && k[i] <= 8'h1D;
        up = (caps_st && letter) != shift;
        len = translate(k[i], up, tb);
      end
      held_key = k[i];
      rep_count = 0;
      rep_limit = first_ticks;
      held_bytes = tb;
      held_len = len;
      for (int j = 0; j < len; j++) bs.push_back(tb[j]);
    end
    prev_keys = k;
    prev_shift = shift;
    prev_ctrl = ctrl;
    queue_bytes(bs, chg, 1'b1);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_NEWLINE_MODE: nl_mode = val[0];
      REG_FIRST_REPEAT: first_ticks = val;
      default: next_ticks = val;
    endcase
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic send_item(logic op, logic [7:0] m, logic [7:0] k [6]);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    modifier_bits_i <= m;
    key_slot_0_i <= k[0];
    key_slot_1_i <= k[1];
    key_slot_2_i <= k[2];
    key_slot_3_i <= k[3];
    key_slot_4_i <= k[4];
    key_slot_5_i <= k[5];
    do @(posedge clk_i); while (!in_ready_o);
    predict_keyboard(op, m, k);
    sent_items++;
  endtask

  function automatic logic [7:0] pick_key();
    case ($urandom_range(9))
      0, 1, 2: return 8'(8'h04 + $urandom_range(25));
      3, 4: return 8'(8'h1E + $urandom_range(26));
      5: return 8'(8'h3A + $urandom_range(11));
      6: return 8'(8'h4F + $urandom_range(3));
      7: return $urandom_range(1) ? KEY_CAPS_LOCK : KEY_NUM_LOCK;
      8: return 8'($urandom_range(255));
      default: return 8'h00;
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [7:0] k [6];
    logic [7:0] m;
    int held;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(2) == 0) begin
        k = '{default: 8'h00};
        held = $urandom_range(8, 40);
        // tick runs push the held key through its repeat delays
        for (int t = 0; t < held && n < count; t++, n++)
          send_item(OP_TICK, 8'($urandom_range(255)), k);
      end else begin
        m = $urandom_range(3) == 0 ? 8'($urandom_range(255)) :
            {2'b00, 1'($urandom_range(1)), 3'b000, 1'($urandom_range(1)), 1'b0};
        foreach (k[i]) k[i] = $urandom_range(2) == 0 ? pick_key() : 8'h00;
        if ($urandom_range(3) == 0) k[$urandom_range(5)] = prev_keys[$urandom_range(5)];
        send_item(OP_REPORT, m, k);
      end
    end
  endtask

  // receiver
  always @(posedge clk_i) begin
    kbd_out_t a, e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("hid_key_report_to_ascii_typematic_test failed");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      a = '{out_char_o, char_valid_o, last_o, caps_lock_led_o, num_lock_led_o,
            led_report_changed_o};
      got_bytes++;
      if (pending_bytes.size() == 0) begin
        $error("unexpected transfer out_char=%h", a.ch);
        errors++;
      end else begin
        e = pending_bytes.pop_front();
        if (row_check) begin
          if (a.ch !== row_ch) $error("out_char table exp %h got %h", row_ch, a.ch);
          if (a.cv !== row_cv) $error("char_valid table exp %b got %b", row_cv, a.cv);
          if (a.ch !== row_ch || a.cv !== row_cv) errors++;
        end
        if (a.ch !== e.ch) begin $error("out_char exp %h got %h", e.ch, a.ch); errors++; end
        if (a.cv !== e.cv) begin $error("char_valid exp %b got %b", e.cv, a.cv); errors++; end
        if (a.lst !== e.lst) begin $error("last exp %b got %b", e.lst, a.lst); errors++; end
        if (a.caps !== e.caps) begin
          $error("caps_lock_led exp %b got %b", e.caps, a.caps);
          errors++;
        end
        if (a.num !== e.num) begin
          $error("num_lock_led exp %b got %b", e.num, a.num);
          errors++;
        end
        if (a.chg !== e.chg) begin
          $error("led_report_changed exp %b got %b", e.chg, a.chg);
          errors++;
        end
      end
    end
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  initial begin
    kbd_row_t rows [$];
    kbd_row_t r;
    logic [7:0] z [6];
    z = '{default: 8'h00};
    nl_mode = 1'b1;
    first_ticks = FIRST_RESET;
    next_ticks = NEXT_RESET;
    prev_keys = '{default: 8'h00};
    prev_shift = 0; prev_ctrl = 0; caps_st = 0; num_st = 0;
    held_key = 0; held_bytes = '{default: 8'h00}; held_len = 0;
    rep_count = 0; rep_limit = FIRST_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    r = '{op: OP_REPORT, mods: 8'h00, k: z, has_exp: 1, exp_ch: 8'h00, exp_cv: 0};
    rows.push_back(r);
    r.k[0] = 8'h04; r.exp_ch = 8'h61; r.exp_cv = 1; rows.push_back(r);
    r.k[0] = 8'h1D; r.mods = 8'h02; r.exp_ch = 8'h5A; rows.push_back(r);
    r.k[0] = 8'h04; r.mods = 8'h01; r.exp_ch = 8'h01; rows.push_back(r);
    r.k[0] = 8'h1E; r.mods = 8'h11; r.has_exp = 0; rows.push_back(r);
    r.k = '{8'h28, 8'h39, 8'h53, 8'h3A, 8'h45, 8'h4F}; r.mods = 8'h00; rows.push_back(r);
    r.k = '{8'h04, 8'h52, 8'h4C, 8'h63, 8'h29, 8'h2B}; r.mods = 8'h20; rows.push_back(r);
    r.k = '{8'h04, 8'h04, 8'h39, 8'h39, 8'hFF, 8'h63}; r.mods = 8'hFF; rows.push_back(r);
    r.k = z; r.mods = 8'h00; rows.push_back(r);
    r.k[0] = 8'h39; rows.push_back(r);
    r.k[0] = 8'h05; rows.push_back(r);
    r.k[0] = 8'h38; r.mods = 8'h02; rows.push_back(r);
    r.k[0] = 8'h2D; r.mods = 8'h02; rows.push_back(r);
    foreach (rows[i]) begin
      row_check = rows[i].has_exp;
      row_ch = rows[i].exp_ch;
      row_cv = rows[i].exp_cv;
      send_item(rows[i].op, rows[i].mods, rows[i].k);
      drain_wait();
      row_check = 1'b0;
    end
    for (int t = 0; t < 70; t++) send_item(OP_TICK, 8'h00, z);
    drain_wait();

    write_reg(REG_NEWLINE_MODE, 8'h00);
    write_reg(REG_FIRST_REPEAT, 8'd1);
    write_reg(REG_NEXT_REPEAT, 8'd1);
    random_phase(60);
    drain_wait();

    send_idle = 55; recv_idle = 24;
    write_reg(REG_NEWLINE_MODE, 8'h01);
    write_reg(REG_FIRST_REPEAT, 8'd255);
    write_reg(REG_NEXT_REPEAT, 8'd255);
    r.k = z; r.k[0] = 8'h28;
    send_item(OP_REPORT, 8'h00, r.k);
    for (int t = 0; t < 260; t++) send_item(OP_TICK, 8'h00, r.k);
    drain_wait();

    send_idle = 0; recv_idle = 0;
    write_reg(REG_FIRST_REPEAT, 8'd3);
    write_reg(REG_NEXT_REPEAT, 8'd2);
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(60);
    join
    drain_wait();

    $display("Covered %0d items and %0d result transfers over four delay settings.",
             sent_items, got_bytes);
    if (errors == 0) $display("hid_key_report_to_ascii_typematic_test passed");
    else $display("hid_key_report_to_ascii_typematic_test failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/hkt_pkg.sv
sv/hkt_lane.sv
sv/hid_key_report_to_ascii_typematic.sv
dv/hid_key_report_to_ascii_typematic_test.sv
